// ===== hw/rtl/bdf_pkg.sv =====
// Shared constants, types and codes of the BDF coefficient unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package bdf_pkg;

   // Arithmetic setup
   localparam int STEP_WIDTH     = 32;
   localparam int COEF_FRAC_BITS = 24;

   // Field widths of the ports
   localparam int STEP_FIELD_W = 32;
   localparam int ORDER_W      = 3;
   localparam int STATUS_W     = 2;
   localparam int COEF_W       = 32;
   localparam int GAMMA_W      = 31;

   localparam int                 MAX_ORDER       = 4;
   localparam logic [ORDER_W-1:0] MAX_ORDER_RESET = ORDER_W'(2);

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ORDER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_STEP = 2'd2;

   // Factor of a product: the largest is 4*h0+3*h1+2*h2+h3 < 10 * 2^STEP_WIDTH
   localparam int FACT_W = STEP_WIDTH + 4;
   localparam int NFACT  = 4;
   localparam int PROD_W = NFACT * FACT_W;

   // Product chains of one lane: numerator, subtrahend, denominator
   localparam int NCHAIN = 3;
   localparam int CH_NUM = 0;
   localparam int CH_SUB = 1;
   localparam int CH_DEN = 2;

   // Lanes: gamma0, then alpha0..alpha3
   localparam int NLANE      = 5;
   localparam int LANE_GAMMA = 0;
   localparam int LANE_ALPHA = 1;

   // Rounding divider: N = num*2^(F+1) + den, D = 2*den, quotient COEF_W bits
   localparam int N_W   = PROD_W + COEF_FRAC_BITS + 2;
   localparam int D_W   = PROD_W + 1;
   localparam int R_W   = D_W;
   localparam int R0_W  = N_W - COEF_W;
   localparam int CMP_W = (R0_W > D_W) ? R0_W : D_W;

   // Lane pipeline: 8 product/prep stages, one overflow stage, one per quotient bit
   localparam int LANE_LAT = COEF_W + 9;

   // Queue between front and back
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef struct packed {
      logic [ORDER_W-1:0]      step_order;
      logic                    uniform_steps;
      logic [STEP_FIELD_W-1:0] step_newest;
      logic [STEP_FIELD_W-1:0] step_back_one;
      logic [STEP_FIELD_W-1:0] step_back_two;
      logic [STEP_FIELD_W-1:0] step_back_three;
   } req_type;

   typedef struct packed {
      logic [GAMMA_W-1:0]       gamma_zero;
      logic signed [COEF_W-1:0] coef_a0;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
      logic signed [COEF_W-1:0] coef_a3;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic [STATUS_W-1:0]              status;
      logic [ORDER_W-1:0]               step_order;
      logic [3:0][STEP_WIDTH-1:0]       steps;
   } queue_entry_type;

   typedef logic [NCHAIN-1:0][NFACT-1:0][FACT_W-1:0] lane_in_type;

   typedef struct packed {
      logic              ovf;
      logic [COEF_W-1:0] quo;
   } lane_out_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bdf_coefficient_calculator_unit.sv =====
// Top level of the variable-step BDF coefficient unit (orders 1 to 4).
// Depends on bdf_pkg, bdf_front, bdf_queue, bdf_back.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_data  (req_type)
//   rsp       out         rsp_valid / rsp_ready   rsp_data  (rsp_type)
//   csr       in          csr_valid / csr_ready   csr_wdata (max_order)
//
// One request per cycle sustained while rsp_ready stays high; rsp_valid rises once the
// request has passed the queue write, issue register, eight product and rounding-prep
// stages, the divider head, the 32-stage restoring divider of each lane (one quotient bit
// per stage) and the result register.
// Reset sets max_order to 2 and empties the queue and the pipeline.
// A held result freezes the back end; the queue keeps taking requests until it
// holds four, then req_ready drops.
`default_nettype none

module bdf_coefficient_calculator_unit
   import bdf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [ORDER_W-1:0] csr_wdata
);

   localparam logic [GAMMA_W-1:0]       GAMMA_ONE = GAMMA_W'(1) << COEF_FRAC_BITS;
   localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;

   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_valid;
   queue_entry_type q_wdata;
   queue_entry_type q_rdata;

   bdf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   bdf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   bdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Rejected requests carry no coefficients
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.gamma_zero == '0 && rsp_data.coef_a0 == '0 &&
         rsp_data.coef_a1 == '0 && rsp_data.coef_a2 == '0 && rsp_data.coef_a3 == '0)
      else $error("error result with nonzero coefficients");

   // gamma0 is at least one for every accepted order
   a_gamma_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |-> rsp_data.gamma_zero >= GAMMA_ONE)
      else $error("gamma0 below one");

   // alpha0 is at least one for every accepted order
   a_alpha0_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |-> rsp_data.coef_a0 >= COEF_ONE)
      else $error("alpha0 below one");

endmodule

`default_nettype wire

// ===== hw/rtl/bdf_front.sv =====
// Front of the BDF unit: max_order register, request classification, queue write.
// Depends on bdf_pkg.
`default_nettype none

module bdf_front
   import bdf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [ORDER_W-1:0] csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   input  wire logic               q_full,
   output logic                    q_push,
   output queue_entry_type         q_wdata
);

   logic [ORDER_W-1:0]         max_order_ff;
   logic [ORDER_W-1:0]         eff_max;
   logic [ORDER_W-1:0]         ord;
   logic [3:0][STEP_WIDTH-1:0] steps;
   logic                       zero_hit;

   // Hold the order limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_order_ff <= MAX_ORDER_RESET;
      end else if (csr_valid && csr_ready) begin
         max_order_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   // Classify the request; uniform mode replaces every step by one
   always_comb begin
      ord     = req_data.step_order;
      eff_max = (max_order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : max_order_ff;
      if (req_data.uniform_steps) begin
         steps = {4{STEP_WIDTH'(1)}};
      end else begin
         steps[0] = STEP_WIDTH'(req_data.step_newest);
         steps[1] = STEP_WIDTH'(req_data.step_back_one);
         steps[2] = STEP_WIDTH'(req_data.step_back_two);
         steps[3] = STEP_WIDTH'(req_data.step_back_three);
      end
      zero_hit = 1'b0;
      for (int i = 1; i < 4; i++) begin
         if (ORDER_W'(i) < ord && steps[i] == '0) begin
            zero_hit = 1'b1;
         end
      end
      q_wdata.steps      = steps;
      q_wdata.step_order = ord;
      if (ord == '0 || ord > eff_max) begin
         q_wdata.status = STATUS_BAD_ORDER;
      end else if (zero_hit) begin
         q_wdata.status = STATUS_ZERO_STEP;
      end else begin
         q_wdata.status = STATUS_OK;
      end
   end

   // Transfer into the queue while it has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/bdf_queue.sv =====
// Short FIFO between the front and the back of the BDF unit.
// Depends on bdf_pkg.
`default_nettype none

module bdf_queue
   import bdf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire queue_entry_type wdata,
   output logic                 full,
   input  wire logic            pop,
   output logic                 valid,
   output queue_entry_type      rdata
);

   queue_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QUEUE_AW+1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign full  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign rdata = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== hw/rtl/bdf_lane.sv =====
// One coefficient lane: three four-factor product chains, then a pipelined
// restoring divider giving round(num * 2^F / den) with an overflow flag.
// Depends on bdf_pkg.
`default_nettype none

module bdf_lane
   import bdf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire lane_in_type opnd,
   output lane_out_type     res
);

   function automatic logic [2*FACT_W-1:0] mul_fact(input logic [FACT_W-1:0] a,
                                                    input logic [FACT_W-1:0] b);
      return (2*FACT_W)'(a) * (2*FACT_W)'(b);
   endfunction

   lane_in_type                             fact_ff;
   logic [NCHAIN-1:0][2*FACT_W-1:0]         p1_ff;
   logic [NCHAIN-1:0][1:0][FACT_W-1:0]      f23_ff;
   logic [NCHAIN-1:0][1:0][2*FACT_W-1:0]    pt2_ff;
   logic [NCHAIN-1:0][FACT_W-1:0]           f3a_ff;
   logic [NCHAIN-1:0][FACT_W-1:0]           f3b_ff;
   logic [NCHAIN-1:0][3*FACT_W-1:0]         p2_ff;
   logic [NCHAIN-1:0][2:0][2*FACT_W-1:0]    pt3_ff;
   logic [NCHAIN-1:0][PROD_W-1:0]           p3_ff;
   logic [PROD_W-1:0]                       num_ff;
   logic [PROD_W-1:0]                       den_ff;
   logic [N_W-1:0]                          n_ff;
   logic [D_W-1:0]                          d_ff;

   logic [R_W-1:0]    rem_ff [COEF_W];
   logic [D_W-1:0]    dv_ff  [COEF_W];
   logic [COEF_W-1:0] nlo_ff [COEF_W];
   logic [COEF_W-1:0] quo_ff [COEF_W+1];
   logic              ovf_ff [COEF_W+1];

   logic [R0_W-1:0]   r0;

   // Product chains: one factor per step, wide operand split into limbs
   always_ff @(posedge clock) begin
      if (en) begin
         fact_ff <= opnd;
         for (int c = 0; c < NCHAIN; c++) begin
            p1_ff[c]     <= mul_fact(fact_ff[c][0], fact_ff[c][1]);
            f23_ff[c]    <= {fact_ff[c][3], fact_ff[c][2]};
            pt2_ff[c][0] <= mul_fact(p1_ff[c][FACT_W-1:0], f23_ff[c][0]);
            pt2_ff[c][1] <= mul_fact(p1_ff[c][2*FACT_W-1:FACT_W], f23_ff[c][0]);
            f3a_ff[c]    <= f23_ff[c][1];
            p2_ff[c]     <= (3*FACT_W)'(pt2_ff[c][0])
                            + ((3*FACT_W)'(pt2_ff[c][1]) << FACT_W);
            f3b_ff[c]    <= f3a_ff[c];
            for (int k = 0; k < 3; k++) begin
               pt3_ff[c][k] <= mul_fact(p2_ff[c][k*FACT_W +: FACT_W], f3b_ff[c]);
            end
            p3_ff[c]     <= PROD_W'(pt3_ff[c][0])
                            + (PROD_W'(pt3_ff[c][1]) << FACT_W)
                            + (PROD_W'(pt3_ff[c][2]) << (2*FACT_W));
         end
         num_ff <= p3_ff[CH_NUM] - p3_ff[CH_SUB];
         den_ff <= p3_ff[CH_DEN];
         // Fold the half-unit rounding into the dividend
         n_ff   <= (N_W'(num_ff) << (COEF_FRAC_BITS + 1)) + N_W'(den_ff);
         d_ff   <= {den_ff, 1'b0};
      end
   end

   // Divider head: flag quotients that do not fit in COEF_W bits
   assign r0 = n_ff[N_W-1:COEF_W];

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= CMP_W'(r0) >= CMP_W'(d_ff);
         rem_ff[0] <= R_W'(r0);
         dv_ff[0]  <= d_ff;
         nlo_ff[0] <= n_ff[COEF_W-1:0];
         quo_ff[0] <= '0;
      end
   end

   // One quotient bit per stage
   for (genvar k = 1; k <= COEF_W; k++) begin : g_div
      logic [R_W:0] trial;
      logic [R_W:0] diff;
      logic         ge;

      always_comb begin
         trial = {rem_ff[k-1], nlo_ff[k-1][COEF_W-1]};
         diff  = trial - (R_W+1)'(dv_ff[k-1]);
         ge    = trial >= (R_W+1)'(dv_ff[k-1]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k] <= {quo_ff[k-1][COEF_W-2:0], ge};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end

      if (k < COEF_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? R_W'(diff) : R_W'(trial);
               dv_ff[k]  <= dv_ff[k-1];
               nlo_ff[k] <= nlo_ff[k-1] << 1;
            end
         end
      end
   end

   assign res.ovf = ovf_ff[COEF_W];
   assign res.quo = quo_ff[COEF_W];

endmodule

`default_nettype wire

// ===== hw/rtl/bdf_back.sv =====
// Back of the BDF unit: factor selection per order, five coefficient lanes,
// saturation, zeroing and the result register. Depends on bdf_pkg, bdf_lane.
`default_nettype none

module bdf_back
   import bdf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire queue_entry_type q_rdata,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_data
);

   localparam logic [COEF_W-1:0] MAX_POS = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] MIN_MAG = {1'b1, {(COEF_W-1){1'b0}}};

   function automatic logic [COEF_W-1:0] sat_pos(input lane_out_type r);
      return (r.ovf || r.quo > MAX_POS) ? MAX_POS : r.quo;
   endfunction

   function automatic logic [COEF_W-1:0] sat_neg(input lane_out_type r);
      logic [COEF_W-1:0] mag;
      mag = (r.ovf || r.quo > MIN_MAG) ? MIN_MAG : r.quo;
      return '0 - mag;
   endfunction

   logic                adv;
   logic                a_valid_ff;
   queue_entry_type     a_entry_ff;
   logic [LANE_LAT-1:0] vld_ff;
   logic [ORDER_W-1:0]  ord_dly_ff [LANE_LAT];
   logic [STATUS_W-1:0] sts_dly_ff [LANE_LAT];
   logic                out_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   lane_in_type  lane_in  [NLANE];
   lane_out_type lane_out [NLANE];

   logic [FACT_W-1:0] h0, h1, h2, h3, s1, s2, s3, t1, t2, u, c4;
   logic [FACT_W-1:0] one;

   // Advance the whole back end unless a result is held
   assign adv   = !out_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   // Issue stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_entry_ff <= q_rdata;
      end
   end

   // Select the factors of every lane for the requested order
   always_comb begin
      one = FACT_W'(1);
      h0  = FACT_W'(a_entry_ff.steps[0]);
      h1  = FACT_W'(a_entry_ff.steps[1]);
      h2  = FACT_W'(a_entry_ff.steps[2]);
      h3  = FACT_W'(a_entry_ff.steps[3]);
      s1  = h0 + h1;
      s2  = s1 + h2;
      s3  = s2 + h3;
      t1  = h1 + h2;
      t2  = t1 + h3;
      u   = h2 + h3;
      c4  = s1 + s2 + s3 + h0;
      for (int l = 0; l < NLANE; l++) begin
         lane_in[l][CH_NUM] = {NFACT{one}};
         lane_in[l][CH_SUB] = '0;
         lane_in[l][CH_DEN] = {NFACT{one}};
      end
      unique case (a_entry_ff.step_order)
         ORDER_W'(2): begin
            lane_in[LANE_GAMMA][CH_NUM][0]   = s1 + h0;
            lane_in[LANE_GAMMA][CH_DEN][0]   = s1;
            lane_in[LANE_ALPHA][CH_NUM][0]   = s1;
            lane_in[LANE_ALPHA][CH_DEN][0]   = h1;
            lane_in[LANE_ALPHA+1][CH_NUM][0] = h0;
            lane_in[LANE_ALPHA+1][CH_NUM][1] = h0;
            lane_in[LANE_ALPHA+1][CH_DEN][0] = s1;
            lane_in[LANE_ALPHA+1][CH_DEN][1] = h1;
         end
         ORDER_W'(3): begin
            lane_in[LANE_GAMMA][CH_NUM][0]   = s1 + h0;
            lane_in[LANE_GAMMA][CH_NUM][1]   = s2 + h0;
            lane_in[LANE_GAMMA][CH_SUB]      = {one, one, h0, h0};
            lane_in[LANE_GAMMA][CH_DEN][0]   = s1;
            lane_in[LANE_GAMMA][CH_DEN][1]   = s2;
            lane_in[LANE_ALPHA][CH_NUM]      = {one, one, s2, s1};
            lane_in[LANE_ALPHA][CH_DEN]      = {one, one, t1, h1};
            lane_in[LANE_ALPHA+1][CH_NUM]    = {one, s2, h0, h0};
            lane_in[LANE_ALPHA+1][CH_DEN]    = {one, h2, h1, s1};
            lane_in[LANE_ALPHA+2][CH_NUM]    = {one, s1, h0, h0};
            lane_in[LANE_ALPHA+2][CH_DEN]    = {one, h2, t1, s2};
         end
         ORDER_W'(4): begin
            lane_in[LANE_GAMMA][CH_NUM]      = {one, s3 + h0, s2 + h0, s1 + h0};
            lane_in[LANE_GAMMA][CH_SUB]      = {one, c4, h0, h0};
            lane_in[LANE_GAMMA][CH_DEN]      = {one, s3, s2, s1};
            lane_in[LANE_ALPHA][CH_NUM]      = {one, s3, s2, s1};
            lane_in[LANE_ALPHA][CH_DEN]      = {one, t2, t1, h1};
            lane_in[LANE_ALPHA+1][CH_NUM]    = {s3, s2, h0, h0};
            lane_in[LANE_ALPHA+1][CH_DEN]    = {u, h2, h1, s1};
            lane_in[LANE_ALPHA+2][CH_NUM]    = {s3, s1, h0, h0};
            lane_in[LANE_ALPHA+2][CH_DEN]    = {h3, h2, t1, s2};
            lane_in[LANE_ALPHA+3][CH_NUM]    = {s2, s1, h0, h0};
            lane_in[LANE_ALPHA+3][CH_DEN]    = {h3, u, t2, s3};
         end
         default: begin
            // order one, and orders outside 2 to 4: unit products
            lane_in[LANE_GAMMA][CH_NUM] = {NFACT{one}};
         end
      endcase
   end

   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      bdf_lane u_lane (
         .clock (clock),
         .en    (adv),
         .opnd  (lane_in[l]),
         .res   (lane_out[l])
      );
   end

   // Carry order and status alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LANE_LAT-2:0], a_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ord_dly_ff[0] <= a_entry_ff.step_order;
         sts_dly_ff[0] <= a_entry_ff.status;
         for (int i = 1; i < LANE_LAT; i++) begin
            ord_dly_ff[i] <= ord_dly_ff[i-1];
            sts_dly_ff[i] <= sts_dly_ff[i-1];
         end
      end
   end

   // Saturate, drop alphas at and above the order, zero on error
   always_comb begin
      logic [COEF_W-1:0] g;
      logic [COEF_W-1:0] a [4];
      g = sat_pos(lane_out[LANE_GAMMA]);
      for (int i = 0; i < 4; i++) begin
         if (ORDER_W'(i) >= ord_dly_ff[LANE_LAT-1]) begin
            a[i] = '0;
         end else if (i % 2 == 1) begin
            a[i] = sat_neg(lane_out[LANE_ALPHA+i]);
         end else begin
            a[i] = sat_pos(lane_out[LANE_ALPHA+i]);
         end
      end
      rsp_in.status = sts_dly_ff[LANE_LAT-1];
      if (sts_dly_ff[LANE_LAT-1] == STATUS_OK) begin
         rsp_in.gamma_zero = g[GAMMA_W-1:0];
         rsp_in.coef_a0    = a[0];
         rsp_in.coef_a1    = a[1];
         rsp_in.coef_a2    = a[2];
         rsp_in.coef_a3    = a[3];
      end else begin
         rsp_in.gamma_zero = '0;
         rsp_in.coef_a0    = '0;
         rsp_in.coef_a1    = '0;
         rsp_in.coef_a2    = '0;
         rsp_in.coef_a3    = '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
